// ===== hw/rtl/msb_first_bit_field_reader_unit_assert.svh =====
// ---------------------------------------------------------------------------
// msb first bit field reader - assertion macros
// Shorthand for clocked assertions that sample on clk and are disabled
// while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_FIELD_READER_UNIT_ASSERT_SVH
`define MSB_FIRST_BIT_FIELD_READER_UNIT_ASSERT_SVH

// same-cycle implication
`define MBFR_ASSERT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MBFR_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mbfr_pkg.sv =====
// ---------------------------------------------------------------------------
// mbfr_pkg
// Shared widths, defaults and codes of the msb first bit field reader.
// ---------------------------------------------------------------------------
`default_nettype none

package mbfr_pkg;

	// fixed stream and field widths
	localparam int BYTE_BITS   = 8;
	localparam int BYTE_W      = 8;
	localparam int BIT_COUNT_W = 7;
	localparam int FIELD_W     = 64;
	localparam int STATUS_W    = 2;
	localparam int AVAIL_W     = 8;
	localparam int OFFSET_W    = 3;

	// parameter defaults
	localparam int BUFFER_BYTES_DEF  = 16;
	localparam int MAX_READ_BITS_DEF = 64;

	// request kinds
	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_READ = 1'b1
	} req_type_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_WIDTH = 2'd1,
		ST_SHORT = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbfr_ifs.sv =====
// ---------------------------------------------------------------------------
// mbfr channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

// request channel: push a byte or read a field
interface mbfr_req_if;
	logic                             valid;
	logic                             ready;
	logic                             req_type;
	logic [mbfr_pkg::BYTE_W-1:0]      byte_in;
	logic [mbfr_pkg::BIT_COUNT_W-1:0] bit_count;

	modport source (output valid, output req_type, output byte_in, output bit_count,
		input ready);
	modport sink (input valid, input req_type, input byte_in, input bit_count,
		output ready);
endinterface

// response channel: one beat per request
interface mbfr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mbfr_pkg::FIELD_W-1:0]  field_value;
	logic [mbfr_pkg::STATUS_W-1:0] status;
	logic                          sticky_error;
	logic [mbfr_pkg::AVAIL_W-1:0]  bits_available;

	modport source (output valid, output field_value, output status,
		output sticky_error, output bits_available, input ready);
	modport sink (input valid, input field_value, input status,
		input sticky_error, input bits_available, output ready);
endinterface

// configuration write channel
interface mbfr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mbfr_pkg::OFFSET_W-1:0] start_bit_offset;

	modport source (output valid, output start_bit_offset, input ready);
	modport sink (input valid, input start_bit_offset, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/msb_first_bit_field_reader_unit.sv =====
// ---------------------------------------------------------------------------
// msb_first_bit_field_reader_unit
// Bit field reader over a byte ring, most significant bit first.
// ---------------------------------------------------------------------------
// Takes one request beat per cycle while req.ready is high and returns
// exactly one response beat per request. The request lands in the input
// register on acceptance and moves to the response register once that one
// is empty or being taken, so a stalled response holds the input register.
// A push appends a byte to a ring of BUFFER_BYTES bytes held in flops unless
// the ring is full; a read returns 0 to MAX_READ_BITS bits right aligned.
// The combinational funnel shifter rotates the ring by the read pointer and
// cuts the field out between the two registers. req.ready follows rsp.ready
// in the same cycle when both registers are full. Ring bytes are not reset;
// reads only ever see bytes that were pushed. start_bit_offset applies to the
// first pushed byte and is to be written while the block is idle.
`default_nettype none

module msb_first_bit_field_reader_unit #(
	parameter int BUFFER_BYTES  = mbfr_pkg::BUFFER_BYTES_DEF,
	parameter int MAX_READ_BITS = mbfr_pkg::MAX_READ_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mbfr_req_if.sink    req,
	mbfr_rsp_if.source  rsp,
	mbfr_cfg_if.sink    cfg
);
	import mbfr_pkg::*;

	localparam int RING_BITS = BUFFER_BYTES * BYTE_BITS;
	localparam int PTR_W     = $clog2(RING_BITS);
	localparam int SLOT_W    = $clog2(BUFFER_BYTES);
	localparam int LANE_W    = $clog2(BYTE_BITS);
	localparam int HELD_W    = $clog2(RING_BITS + 1);
	localparam int CNT_W     = $clog2(MAX_READ_BITS + 1);
	localparam int CMP_W     = (HELD_W > BIT_COUNT_W) ? HELD_W : BIT_COUNT_W;
	localparam int WIN_BYTES = (MAX_READ_BITS + 2 * BYTE_BITS - 2) / BYTE_BITS;
	localparam int WIN_BITS  = WIN_BYTES * BYTE_BITS;

	// input register
	logic                   v_s1;
	req_type_t              type_s1;
	logic [BYTE_W-1:0]      byte_s1;
	logic [BIT_COUNT_W-1:0] count_s1;

	// reader state
	logic [BYTE_W-1:0]   ring_q [BUFFER_BYTES];
	logic [PTR_W-1:0]    rptr_q;
	logic [SLOT_W-1:0]   wptr_q;
	logic [HELD_W-1:0]   held_q;
	logic                pending_q;
	logic                err_q;
	logic [OFFSET_W-1:0] offset_q;

	// response register
	logic                rsp_v_q;
	logic [FIELD_W-1:0]  value_q;
	status_t             status_q;
	logic                sticky_q;
	logic [AVAIL_W-1:0]  avail_q;

	// next state
	logic [PTR_W-1:0]         rptr_n;
	logic [SLOT_W-1:0]        wptr_n;
	logic [HELD_W-1:0]        held_n;
	logic                     pending_n;
	logic                     err_n;
	logic                     ring_we;
	status_t                  status_n;
	logic [MAX_READ_BITS-1:0] value_n;

	logic advance;
	logic req_fire;
	logic cfg_fire;

	// handshake
	assign advance   = v_s1 && (!rsp_v_q || rsp.ready);
	assign req.ready = !v_s1 || advance;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid;

	// ring occupancy in bits, counting a partly read head byte
	logic [HELD_W:0] occ;
	logic            full;
	assign occ  = (HELD_W+1)'(held_q) + (HELD_W+1)'(rptr_q[LANE_W-1:0]);
	assign full = (occ >> LANE_W) >= (HELD_W+1)'(BUFFER_BYTES);

	// flatten the ring, slot 0 at the top
	logic [RING_BITS-1:0]   flat;
	logic [2*RING_BITS-1:0] dbl;
	logic [2*RING_BITS-1:0] byte_rot;
	logic [WIN_BITS-1:0]    win;
	logic [WIN_BITS-1:0]    bit_rot;
	logic [MAX_READ_BITS-1:0] top;

	always_comb begin
		for (int i = 0; i < BUFFER_BYTES; i++) begin
			flat[RING_BITS-1-i*BYTE_BITS -: BYTE_BITS] = ring_q[i];
		end
	end

	// funnel shift: whole bytes, then the bit lane
	assign dbl      = {flat, flat};
	assign byte_rot = dbl << {rptr_q[PTR_W-1:LANE_W], {LANE_W{1'b0}}};
	assign win      = byte_rot[2*RING_BITS-1 -: WIN_BITS];
	assign bit_rot  = win << rptr_q[LANE_W-1:0];
	assign top      = bit_rot[WIN_BITS-1 -: MAX_READ_BITS];

	// right align the field
	logic [CNT_W-1:0]         cnt_n;
	logic [CNT_W-1:0]         shamt;
	logic [MAX_READ_BITS-1:0] extracted;
	assign cnt_n     = count_s1[CNT_W-1:0];
	assign shamt     = CNT_W'(MAX_READ_BITS) - cnt_n;
	assign extracted = (cnt_n == '0) ? '0 : (top >> shamt);

	// read checks and pointer advance
	logic           too_wide;
	logic           too_short;
	logic [PTR_W:0] rsum;
	logic [PTR_W:0] rwrap;
	assign too_wide  = count_s1 > BIT_COUNT_W'(MAX_READ_BITS);
	assign too_short = CMP_W'(count_s1) > CMP_W'(held_q);
	assign rsum      = (PTR_W+1)'(rptr_q) + (PTR_W+1)'(cnt_n);
	assign rwrap     = (rsum >= (PTR_W+1)'(RING_BITS)) ? rsum - (PTR_W+1)'(RING_BITS) : rsum;

	// request processing
	always_comb begin
		rptr_n    = rptr_q;
		wptr_n    = wptr_q;
		held_n    = held_q;
		pending_n = pending_q;
		err_n     = err_q;
		ring_we   = 1'b0;
		status_n  = ST_OK;
		value_n   = '0;
		case (type_s1)
			REQ_PUSH: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					ring_we = 1'b1;
					wptr_n  = (wptr_q == SLOT_W'(BUFFER_BYTES - 1)) ? '0 : wptr_q + SLOT_W'(1);
					if (pending_q) begin
						rptr_n    = PTR_W'(offset_q);
						held_n    = held_q + HELD_W'(BYTE_BITS) - HELD_W'(offset_q);
						pending_n = 1'b0;
					end else begin
						held_n = held_q + HELD_W'(BYTE_BITS);
					end
				end
			end
			REQ_READ: begin
				if (too_wide) begin
					status_n = ST_WIDTH;
					err_n    = 1'b1;
				end else if (too_short) begin
					status_n = ST_SHORT;
					err_n    = 1'b1;
				end else begin
					value_n = extracted;
					rptr_n  = rwrap[PTR_W-1:0];
					held_n  = held_q - HELD_W'(cnt_n);
				end
			end
			default: begin
				status_n = ST_OK;
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_fire) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			type_s1  <= req_type_t'(req.req_type);
			byte_s1  <= req.byte_in;
			count_s1 <= req.bit_count;
		end
	end

	// reader state and offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q    <= '0;
			wptr_q    <= '0;
			held_q    <= '0;
			pending_q <= 1'b1;
			err_q     <= 1'b0;
			offset_q  <= '0;
		end else begin
			if (advance) begin
				rptr_q    <= rptr_n;
				wptr_q    <= wptr_n;
				held_q    <= held_n;
				pending_q <= pending_n;
				err_q     <= err_n;
			end
			if (cfg_fire) begin
				offset_q <= cfg.start_bit_offset;
				if (pending_q) begin
					rptr_q <= PTR_W'(cfg.start_bit_offset);
				end
			end
		end
	end

	// ring bytes, no reset
	always_ff @(posedge clk) begin
		if (advance && ring_we) begin
			ring_q[wptr_q] <= byte_s1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (advance) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_q  <= FIELD_W'(value_n);
			status_q <= status_n;
			sticky_q <= err_n;
			avail_q  <= AVAIL_W'(held_n);
		end
	end

	assign rsp.valid          = rsp_v_q;
	assign rsp.field_value    = value_q;
	assign rsp.status         = status_q;
	assign rsp.sticky_error   = sticky_q;
	assign rsp.bits_available = avail_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mbfr_checker.sv =====
// ---------------------------------------------------------------------------
// mbfr_checker
// Port-level checks on the response side of the bit field reader.
// ---------------------------------------------------------------------------
`default_nettype none

`include "msb_first_bit_field_reader_unit_assert.svh"

module mbfr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [mbfr_pkg::FIELD_W-1:0]  field_value,
	input logic [mbfr_pkg::STATUS_W-1:0] status,
	input logic                          sticky_error,
	input logic [mbfr_pkg::AVAIL_W-1:0]  bits_available
);
	import mbfr_pkg::*;

	// remembers a delivered beat with the error flag up
	logic seen_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_err_q <= 1'b0;
		end else if (rsp_valid && rsp_ready && sticky_error) begin
			seen_err_q <= 1'b1;
		end
	end

	// stalled beat holds
	`MBFR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(field_value) && $stable(status) && $stable(sticky_error) && $stable(bits_available), "response changed while stalled")

	// any non-ok status carries a zero field
	`MBFR_ASSERT(a_err_value_zero, rsp_valid && (status != ST_OK), field_value == '0, "non-zero field on error or push")

	// a read error raises the flag in its own beat
	`MBFR_ASSERT(a_read_err_sticky, rsp_valid && (status == ST_WIDTH || status == ST_SHORT), sticky_error, "read error without sticky flag")

	// flag never drops once delivered
	`MBFR_ASSERT(a_sticky_holds, rsp_valid && seen_err_q, sticky_error, "sticky flag cleared")

endmodule

bind msb_first_bit_field_reader_unit mbfr_checker u_mbfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.field_value    (rsp.field_value),
	.status         (rsp.status),
	.sticky_error   (rsp.sticky_error),
	.bits_available (rsp.bits_available)
);

`default_nettype wire
